@@ hdl/utf8_decode_display_width_assert.svh @@
// assertion macros shared by the decoder rtl
`ifndef UTF8_DECODE_DISPLAY_WIDTH_ASSERT_SVH
`define UTF8_DECODE_DISPLAY_WIDTH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/utf8dw_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8dw_pkg
// Constants and the display width lookup for the utf-8 width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8dw_pkg;

	localparam int POINT_BITS = 21;
	localparam int COLS_BITS  = 2;
	localparam int WSUM_BITS  = 16;

	typedef logic [POINT_BITS-1:0] point_t;
	typedef logic [COLS_BITS-1:0]  cols_t;

	localparam point_t REPL_POINT = 21'h00FFFD;

	localparam logic [7:0] MASK_L2   = 8'hE0;
	localparam logic [7:0] CODE_L2   = 8'hC0;
	localparam logic [7:0] MASK_L3   = 8'hF0;
	localparam logic [7:0] CODE_L3   = 8'hE0;
	localparam logic [7:0] MASK_L4   = 8'hF8;
	localparam logic [7:0] CODE_L4   = 8'hF0;
	localparam logic [7:0] MASK_CONT = 8'hC0;
	localparam logic [7:0] CODE_CONT = 8'h80;
	localparam logic [7:0] BITS_CONT = 8'h3F;
	localparam logic [7:0] BITS_L2   = 8'h1F;
	localparam logic [7:0] BITS_L3   = 8'h0F;
	localparam logic [7:0] BITS_L4   = 8'h07;

	localparam cols_t COLS_ZERO = 2'd0;
	localparam cols_t COLS_ONE  = 2'd1;
	localparam cols_t COLS_TWO  = 2'd2;

	function automatic logic in_span(input point_t cp, input point_t lo, input point_t hi);
		return (cp >= lo) && (cp <= hi);
	endfunction

	function automatic logic is_zero_width(input point_t cp);
		return in_span(cp, 21'h00000, 21'h0001F) || in_span(cp, 21'h0007F, 21'h0009F) ||
			in_span(cp, 21'h00300, 21'h0036F) || in_span(cp, 21'h00483, 21'h00489) ||
			in_span(cp, 21'h00591, 21'h005BD) || in_span(cp, 21'h005BF, 21'h005BF) ||
			in_span(cp, 21'h005C1, 21'h005C2) || in_span(cp, 21'h005C4, 21'h005C5) ||
			in_span(cp, 21'h005C7, 21'h005C7) || in_span(cp, 21'h00610, 21'h0061A) ||
			in_span(cp, 21'h0064B, 21'h0065F) || in_span(cp, 21'h00670, 21'h00670) ||
			in_span(cp, 21'h006D6, 21'h006DC) || in_span(cp, 21'h006DF, 21'h006E4) ||
			in_span(cp, 21'h006E7, 21'h006E8) || in_span(cp, 21'h006EA, 21'h006ED) ||
			in_span(cp, 21'h00711, 21'h00711) || in_span(cp, 21'h00730, 21'h0074A) ||
			in_span(cp, 21'h007A6, 21'h007B0) || in_span(cp, 21'h007EB, 21'h007F3) ||
			in_span(cp, 21'h00816, 21'h00823) || in_span(cp, 21'h00825, 21'h0082D) ||
			in_span(cp, 21'h00900, 21'h00902) || in_span(cp, 21'h0093A, 21'h0093A) ||
			in_span(cp, 21'h0093C, 21'h0093C) || in_span(cp, 21'h00941, 21'h00948) ||
			in_span(cp, 21'h0094D, 21'h0094D) || in_span(cp, 21'h00951, 21'h00957) ||
			in_span(cp, 21'h00962, 21'h00963) || in_span(cp, 21'h01160, 21'h011FF) ||
			in_span(cp, 21'h020D0, 21'h020F0) || in_span(cp, 21'h0FE20, 21'h0FE2F) ||
			in_span(cp, 21'h0FEFF, 21'h0FEFF) || in_span(cp, 21'hE0000, 21'hE01FF);
	endfunction

	function automatic logic is_wide(input point_t cp);
		return in_span(cp, 21'h01100, 21'h0115F) || in_span(cp, 21'h02E80, 21'h02EFF) ||
			in_span(cp, 21'h02F00, 21'h02FDF) || in_span(cp, 21'h02FF0, 21'h02FFF) ||
			in_span(cp, 21'h03000, 21'h0303F) || in_span(cp, 21'h03040, 21'h033FF) ||
			in_span(cp, 21'h03400, 21'h04DBF) || in_span(cp, 21'h04E00, 21'h09FFF) ||
			in_span(cp, 21'h0A000, 21'h0A4CF) || in_span(cp, 21'h0A960, 21'h0A97F) ||
			in_span(cp, 21'h0AC00, 21'h0D7AF) || in_span(cp, 21'h0D7B0, 21'h0D7FF) ||
			in_span(cp, 21'h0F900, 21'h0FAFF) || in_span(cp, 21'h0FE10, 21'h0FE1F) ||
			in_span(cp, 21'h0FE30, 21'h0FE4F) || in_span(cp, 21'h0FF00, 21'h0FF60) ||
			in_span(cp, 21'h0FFE0, 21'h0FFE6) || in_span(cp, 21'h1B000, 21'h1B0FF) ||
			in_span(cp, 21'h1F004, 21'h1F004) || in_span(cp, 21'h1F0CF, 21'h1F0CF) ||
			in_span(cp, 21'h1F200, 21'h1F2FF) || in_span(cp, 21'h1F300, 21'h1F64F) ||
			in_span(cp, 21'h1F900, 21'h1F9FF) || in_span(cp, 21'h20000, 21'h2FFFD) ||
			in_span(cp, 21'h30000, 21'h3FFFD);
	endfunction

	function automatic cols_t cols_of(input point_t cp);
		cols_t c;
		if (is_zero_width(cp)) begin
			c = COLS_ZERO;
		end else if (is_wide(cp)) begin
			c = COLS_TWO;
		end else begin
			c = COLS_ONE;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hdl/utf8_decode_display_width.sv @@
// ----------------------------------------------------------------------------
// utf8_decode_display_width
// UTF-8 byte stream decoder with per-character display width and string sum.
// ----------------------------------------------------------------------------
// One byte is taken per cycle into an input register while in_stall is low;
// decode, the width range tables and the saturating sum sit between that
// register and the result register, with no other register in between.
// Most bytes give zero or one result and keep the full rate of one byte per
// cycle while out_stall is low. A byte that gives two results (a broken
// sequence then a complete character or a new bad lead, or an unfinished
// sequence cut by the end flag) holds the input until its second result is
// emitted, as the result channel carries one code point per cycle. The
// running width sum and decoder clear after the result flagged string_done.
`default_nettype none
`include "utf8_decode_display_width_assert.svh"

module utf8_decode_display_width #(
	parameter int SUM_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [7:0]                           data_byte,
	input  wire                                  end_of_string,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [utf8dw_pkg::POINT_BITS-1:0]    code_point,
	output logic [utf8dw_pkg::COLS_BITS-1:0]     char_width,
	output logic                                 malformed,
	output logic [utf8dw_pkg::WSUM_BITS-1:0]     width_sum,
	output logic                                 string_done
);
	import utf8dw_pkg::*;

	// input register
	logic       valid_s1;
	logic       phase_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// decoder state
	point_t        partial_q;
	logic [1:0]    pend_q;
	logic [SUM_BITS-1:0] sum_q;

	// result register
	logic   out_valid_q;
	point_t cp_q;
	cols_t  cols_q;
	logic   bad_q;
	logic [SUM_BITS-1:0] wsum_q;
	logic   done_q;

	// decode
	logic   is_cont, is_ascii, is_l2, is_l3, is_l4, is_multi;
	logic   mid_bad, do_lead, cont_step, cont_done, lead_res, end_res;
	logic [1:0] lead_len, pend_after;
	point_t cont_point, lead_point, lead_part, partial_next;
	logic   lead_bad;
	logic [1:0] n_res;
	point_t r0_cp, r1_cp, cur_cp;
	logic   r0_bad, r1_bad, cur_bad, cur_last, cur_done;
	cols_t  cur_cols;
	logic [SUM_BITS:0]   sum_add;
	logic [SUM_BITS-1:0] sum_next;
	logic [SUM_BITS+WSUM_BITS-1:0] wsum_ext;
	logic   emit, s1_done, s1_load;

	always_comb begin
		is_cont  = (byte_s1 & MASK_CONT) == CODE_CONT;
		is_ascii = !byte_s1[7];
		is_l2    = (byte_s1 & MASK_L2) == CODE_L2;
		is_l3    = (byte_s1 & MASK_L3) == CODE_L3;
		is_l4    = (byte_s1 & MASK_L4) == CODE_L4;
		is_multi = is_l2 || is_l3 || is_l4;

		lead_len  = is_l2 ? 2'd1 : (is_l3 ? 2'd2 : 2'd3);
		lead_part = is_l2 ? point_t'(byte_s1 & BITS_L2) :
			(is_l3 ? point_t'(byte_s1 & BITS_L3) : point_t'(byte_s1 & BITS_L4));

		cont_step  = (pend_q != 2'd0) && is_cont;
		mid_bad    = (pend_q != 2'd0) && !is_cont;
		do_lead    = (pend_q == 2'd0) || mid_bad;
		cont_done  = cont_step && (pend_q == 2'd1);
		cont_point = {partial_q[POINT_BITS-7:0], byte_s1[5:0] & BITS_CONT[5:0]};

		lead_res   = do_lead && !is_multi;
		lead_point = is_ascii ? point_t'(byte_s1) : REPL_POINT;
		lead_bad   = !is_ascii;

		if (cont_step) begin
			pend_after   = pend_q - 2'd1;
			partial_next = cont_point;
		end else if (do_lead && is_multi) begin
			pend_after   = lead_len;
			partial_next = lead_part;
		end else begin
			pend_after   = 2'd0;
			partial_next = partial_q;
		end

		// sequence cut short by the end flag
		end_res = eos_s1 && (pend_after != 2'd0);

		n_res = 2'(cont_done) + 2'(mid_bad) + 2'(lead_res) + 2'(end_res);

		if (cont_done) begin
			r0_cp = cont_point; r0_bad = 1'b0;
		end else if (mid_bad) begin
			r0_cp = REPL_POINT; r0_bad = 1'b1;
		end else if (lead_res) begin
			r0_cp = lead_point; r0_bad = lead_bad;
		end else begin
			r0_cp = REPL_POINT; r0_bad = 1'b1;
		end
		if (mid_bad && lead_res) begin
			r1_cp = lead_point; r1_bad = lead_bad;
		end else begin
			r1_cp = REPL_POINT; r1_bad = 1'b1;
		end

		cur_cp   = phase_s1 ? r1_cp : r0_cp;
		cur_bad  = phase_s1 ? r1_bad : r0_bad;
		cur_last = (n_res == 2'd1) || phase_s1;
		cur_done = eos_s1 && cur_last;
		cur_cols = cols_of(cur_cp);

		sum_add  = {1'b0, sum_q} + (SUM_BITS+1)'(cur_cols);
		sum_next = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];

		emit    = valid_s1 && (n_res != 2'd0) && (!out_valid_q || !out_stall);
		s1_done = valid_s1 && ((n_res == 2'd0) || (emit && cur_last));
		s1_load = in_valid && !in_stall;
	end

	assign in_stall = valid_s1 && !s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_done) begin
				phase_s1 <= 1'b0;
			end else if (emit) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pend_q    <= 2'd0;
			sum_q     <= '0;
		end else begin
			if (s1_done) begin
				if (eos_s1) begin
					partial_q <= '0;
					pend_q    <= 2'd0;
				end else begin
					partial_q <= partial_next;
					pend_q    <= pend_after;
				end
			end
			if (emit) begin
				sum_q <= cur_done ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cp_q   <= cur_cp;
			cols_q <= cur_cols;
			bad_q  <= cur_bad;
			wsum_q <= sum_next;
			done_q <= cur_done;
		end
	end

	assign wsum_ext    = {{WSUM_BITS{1'b0}}, wsum_q};
	assign out_valid   = out_valid_q;
	assign code_point  = cp_q;
	assign char_width  = cols_q;
	assign malformed   = bad_q;
	assign width_sum   = wsum_ext[WSUM_BITS-1:0];
	assign string_done = done_q;

	`ASSERT_IMP(a_stall_needs_item, clk, arst_n, in_stall, valid_s1, "stall without held item")
	`ASSERT_IMP(a_phase_needs_item, clk, arst_n, phase_s1, valid_s1, "second result without item")
	`ASSERT_NXT(a_sum_clears, clk, arst_n, emit && cur_done, sum_q == '0, "sum not cleared at end")
	`ASSERT_NXT(a_state_clears, clk, arst_n, s1_done && eos_s1, pend_q == 2'd0,
		"decoder not idle after end")
	`ASSERT_IMP(a_repl_cols, clk, arst_n, out_valid_q && bad_q,
		(cp_q == REPL_POINT) && (cols_q == COLS_ONE), "bad replacement result")

endmodule

`default_nettype wire

@@ bench/tb_utf8_decode_display_width.sv @@
// ----------------------------------------------------------------------------
// tb_utf8_decode_display_width
// Self-checking bench for the utf-8 decoder with display width and width sum.
// Byte items are queued up front, sent in random bursts and predicted at the
// input handshake; each result is checked field by field against the oldest
// prediction while the result side stalls on a changing pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_utf8_decode_display_width;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
		logic       drain;
	} text_item_t;

	typedef struct packed {
		utf8dw_pkg::point_t cp;
		utf8dw_pkg::cols_t  cols;
		logic               bad;
		logic [15:0]        sum;
		logic               done;
	} glyph_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_EVERY3,
		STALL_LONG
	} stall_mode_t;

	localparam utf8dw_pkg::point_t REPLACEMENT = 21'h00FFFD;
	localparam int unsigned        SUM_MAX     = 32'h0000_FFFF;
	localparam int                 RAND_BYTES  = 1100;
	localparam int                 NUM_EDGES   = 34;

	// code points on both sides of the width table boundaries
	int span_edges [0:NUM_EDGES-1] = '{
		'h1F, 'h20, 'h7E, 'h7F, 'h9F, 'hA0, 'h2FF, 'h300, 'h36F, 'h370,
		'h10FF, 'h1100, 'h115F, 'h1160, 'h11FF, 'h1200, 'hFE1F, 'hFE20,
		'hFE2F, 'hFE30, 'hFEFF, 'hFF60, 'hFF61, 'hFFFD, 'h1F600, 'h1F64F,
		'h1F650, 'h2FFFD, 'h2FFFE, 'h3FFFD, 'h3FFFE, 'hE0000, 'hE01FF, 'hE0200
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                           in_valid      = 1'b0;
	logic                           in_stall;
	logic [7:0]                     data_byte     = 8'h00;
	logic                           end_of_string = 1'b0;
	logic                           out_valid;
	logic                           out_stall     = 1'b0;
	logic [utf8dw_pkg::POINT_BITS-1:0] code_point;
	logic [utf8dw_pkg::COLS_BITS-1:0]  char_width;
	logic                           malformed;
	logic [utf8dw_pkg::WSUM_BITS-1:0]  width_sum;
	logic                           string_done;

	text_item_t text_q [$];
	glyph_t     glyph_q [$];
	text_item_t drv_item;
	logic       drain_next = 1'b0;

	// decoder state mirrored from the input side
	utf8dw_pkg::point_t acc_point = '0;
	logic [1:0]         cont_left = '0;
	int unsigned        col_sum   = 0;

	int errors      = 0;
	int cycles      = 0;
	int cycle_limit = 32'h7FFF_FFFF;
	int burst_left  = 0;
	int gap_left    = 0;

	stall_mode_t stall_mode = STALL_NONE;
	logic [7:0]  stall_tick = '0;

	utf8_decode_display_width DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_point    (code_point),
		.char_width    (char_width),
		.malformed     (malformed),
		.width_sum     (width_sum),
		.string_done   (string_done)
	);

	always #10 clk = ~clk;

	function automatic bit rng(input int unsigned v, input int unsigned lo, input int unsigned hi);
		return (v >= lo) && (v <= hi);
	endfunction

	function automatic utf8dw_pkg::cols_t cols_for(input utf8dw_pkg::point_t cp);
		int unsigned v;
		v = 32'(cp);
		if (rng(v, 'h0, 'h1F) || rng(v, 'h7F, 'h9F) || rng(v, 'h300, 'h36F) ||
				rng(v, 'h483, 'h489) || rng(v, 'h591, 'h5BD) || v == 'h5BF ||
				rng(v, 'h5C1, 'h5C2) || rng(v, 'h5C4, 'h5C5) || v == 'h5C7 ||
				rng(v, 'h610, 'h61A) || rng(v, 'h64B, 'h65F) || v == 'h670 ||
				rng(v, 'h6D6, 'h6DC) || rng(v, 'h6DF, 'h6E4) || rng(v, 'h6E7, 'h6E8) ||
				rng(v, 'h6EA, 'h6ED) || v == 'h711 || rng(v, 'h730, 'h74A) ||
				rng(v, 'h7A6, 'h7B0) || rng(v, 'h7EB, 'h7F3) || rng(v, 'h816, 'h823) ||
				rng(v, 'h825, 'h82D) || rng(v, 'h900, 'h902) || v == 'h93A ||
				v == 'h93C || rng(v, 'h941, 'h948) || v == 'h94D ||
				rng(v, 'h951, 'h957) || rng(v, 'h962, 'h963) || rng(v, 'h1160, 'h11FF) ||
				rng(v, 'h20D0, 'h20F0) || rng(v, 'hFE20, 'hFE2F) || v == 'hFEFF ||
				rng(v, 'hE0000, 'hE01FF)) begin
			return 2'd0;
		end
		if (rng(v, 'h1100, 'h115F) || rng(v, 'h2E80, 'h2FDF) || rng(v, 'h2FF0, 'h303F) ||
				rng(v, 'h3040, 'h4DBF) || rng(v, 'h4E00, 'hA4CF) || rng(v, 'hA960, 'hA97F) ||
				rng(v, 'hAC00, 'hD7FF) || rng(v, 'hF900, 'hFAFF) || rng(v, 'hFE10, 'hFE1F) ||
				rng(v, 'hFE30, 'hFE4F) || rng(v, 'hFF00, 'hFF60) || rng(v, 'hFFE0, 'hFFE6) ||
				rng(v, 'h1B000, 'h1B0FF) || v == 'h1F004 || v == 'h1F0CF ||
				rng(v, 'h1F200, 'h1F64F) || rng(v, 'h1F900, 'h1F9FF) ||
				rng(v, 'h20000, 'h2FFFD) || rng(v, 'h30000, 'h3FFFD)) begin
			return 2'd2;
		end
		return 2'd1;
	endfunction

	task automatic push_glyph(input utf8dw_pkg::point_t cp, input logic bad);
		glyph_t g;
		g.cp   = cp;
		g.cols = cols_for(cp);
		g.bad  = bad;
		col_sum = col_sum + g.cols;
		if (col_sum > SUM_MAX) begin
			col_sum = SUM_MAX;
		end
		g.sum  = col_sum[15:0];
		g.done = 1'b0;
		glyph_q.push_back(g);
	endtask

	task automatic take_lead(input logic [7:0] b);
		if (b < 8'h80) begin
			push_glyph(utf8dw_pkg::point_t'(b), 1'b0);
		end else if ((b & 8'hE0) == 8'hC0) begin
			acc_point = utf8dw_pkg::point_t'(b & 8'h1F);
			cont_left = 2'd1;
		end else if ((b & 8'hF0) == 8'hE0) begin
			acc_point = utf8dw_pkg::point_t'(b & 8'h0F);
			cont_left = 2'd2;
		end else if ((b & 8'hF8) == 8'hF0) begin
			acc_point = utf8dw_pkg::point_t'(b & 8'h07);
			cont_left = 2'd3;
		end else begin
			push_glyph(REPLACEMENT, 1'b1);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eos);
		glyph_t g;
		if (cont_left != 0) begin
			if ((b & 8'hC0) == 8'h80) begin
				acc_point = {acc_point[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 0) begin
					push_glyph(acc_point, 1'b0);
				end
			end else begin
				// broken sequence, then the byte starts over as a lead
				cont_left = 2'd0;
				push_glyph(REPLACEMENT, 1'b1);
				take_lead(b);
			end
		end else begin
			take_lead(b);
		end
		if (eos) begin
			if (cont_left != 0) begin
				cont_left = 2'd0;
				push_glyph(REPLACEMENT, 1'b1);
			end
			g = glyph_q.pop_back();
			g.done = 1'b1;
			glyph_q.push_back(g);
			acc_point = '0;
			col_sum   = 0;
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic eos);
		text_item_t t;
		t.data  = b;
		t.eos   = eos;
		t.drain = drain_next;
		drain_next = 1'b0;
		text_q.push_back(t);
	endtask

	// encode with len bytes (longer than needed gives an overlong form),
	// sending only the first keep of them
	task automatic add_char(input int cp, input int len, input int keep, input logic eos);
		logic [7:0] seq [0:3];
		int i;
		if (len == 1) begin
			seq[0] = cp[7:0];
		end else begin
			seq[0] = (len == 2) ? 8'hC0 : (len == 3) ? 8'hE0 : 8'hF0;
			seq[0] = seq[0] | 8'(cp >> (6 * (len - 1)));
			for (i = 1; i < len; i++) begin
				seq[i] = 8'h80 | 8'((cp >> (6 * (len - 1 - i))) & 'h3F);
			end
		end
		for (i = 0; i < keep; i++) begin
			add_byte(seq[i], eos && (i == keep - 1));
		end
	endtask

	function automatic int min_len(input int cp);
		return (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
	endfunction

	function automatic int pick_point();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(0, 'h7F);
			2: return $urandom_range('h80, 'h7FF);
			3: return $urandom_range('h800, 'hFFFF);
			4: return $urandom_range('h3000, 'h9FFF);
			5: return $urandom_range('hAC00, 'hD7FF);
			6: return $urandom_range('h10000, 'h1FFFFF);
			7: return $urandom_range('h1F000, 'h3FFFF);
			default: return span_edges[$urandom_range(0, NUM_EDGES - 1)];
		endcase
	endfunction

	task automatic build_random_text();
		int base, nchar, c, cp, len, sel, strings;
		logic last;
		base = text_q.size();
		strings = 0;
		while (text_q.size() - base < RAND_BYTES) begin
			nchar = $urandom_range(1, 30);
			strings++;
			if (strings % 12 == 0) begin
				drain_next = 1'b1;
			end
			for (c = 0; c < nchar; c++) begin
				last = (c == nchar - 1);
				sel = $urandom_range(0, 99);
				if (sel < 75) begin
					cp = pick_point();
					len = min_len(cp);
					if (len < 4 && $urandom_range(0, 9) == 0) begin
						len = $urandom_range(len + 1, 4);
					end
					add_char(cp, len, len, last);
				end else if (sel < 85) begin
					add_byte(8'($urandom_range(0, 255)), last);
				end else if (sel < 93) begin
					// sequence cut short
					cp = $urandom_range('h80, 'h1FFFFF);
					len = min_len(cp);
					add_char(cp, len, $urandom_range(1, len - 1), last);
				end else begin
					add_byte(8'($urandom_range('h80, 'hBF)), last);
				end
			end
		end
	endtask

	// sender: bursts of items with random gaps, held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			data_byte     <= 8'h00;
			end_of_string <= 1'b0;
			burst_left    <= 0;
			gap_left      <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (text_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (text_q[0].drain && (in_valid || glyph_q.size() != 0)) begin
				// hold off until every pending result has come out
				in_valid <= 1'b0;
			end else begin
				drv_item = text_q.pop_front();
				in_valid      <= 1'b1;
				data_byte     <= drv_item.data;
				end_of_string <= drv_item.eos;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 48);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall pattern, with a new random mode picked when stall_tick[5:0] is zero
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= STALL_NONE;
			stall_tick <= '0;
		end else begin
			stall_tick <= stall_tick + 8'd1;
			if (stall_tick[5:0] == 6'd0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
			end
			case (stall_mode)
				STALL_NONE:   out_stall <= 1'b0;
				STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
				STALL_EVERY3: out_stall <= (stall_tick % 3 == 0);
				STALL_LONG:   out_stall <= stall_tick[3];
				default:      out_stall <= 1'b0;
			endcase
		end
	end

	// check results first, then predict from the byte taken at this edge
	always @(posedge clk) begin
		glyph_t want, got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.cp   = code_point;
				got.cols = char_width;
				got.bad  = malformed;
				got.sum  = width_sum;
				got.done = string_done;
				if (glyph_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result at cycle %0d: cp=%h cols=%0d bad=%b sum=%0d done=%b",
							cycles, got.cp, got.cols, got.bad, got.sum, got.done);
					end
				end else begin
					want = glyph_q.pop_front();
					if (got.cp !== want.cp || got.cols !== want.cols || got.bad !== want.bad ||
							got.sum !== want.sum || got.done !== want.done) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at cycle %0d: expected cp=%h cols=%0d bad=%b sum=%0d done=%b",
								cycles, want.cp, want.cols, want.bad, want.sum, want.done);
							$display("  got cp=%h cols=%0d bad=%b sum=%0d done=%b",
								got.cp, got.cols, got.bad, got.sum, got.done);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(data_byte, end_of_string);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= cycle_limit) begin
			$display("tb_utf8_decode_display_width: FAIL");
			$finish;
		end
	end

	initial begin
		// nul, ascii, a control char, 2-, 3- and 4-byte forms up to the top point
		add_byte(8'h00, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'h7F, 1'b0);
		add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
		add_byte(8'hE4, 1'b0); add_byte(8'hB8, 1'b0); add_byte(8'hAD, 1'b0);
		add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b1);
		// bad leads, broken sequences and a broken sequence cut by a bad lead at the end
		add_byte(8'h80, 1'b0); add_byte(8'hFF, 1'b0);
		add_byte(8'hE4, 1'b0); add_byte(8'h41, 1'b0);
		add_byte(8'hC3, 1'b0); add_byte(8'hFF, 1'b1);
		// unfinished at the end flag, new lead cut by the end flag, bad lead alone
		add_byte(8'hE4, 1'b0); add_byte(8'hB8, 1'b1);
		add_byte(8'hC3, 1'b0); add_byte(8'hC3, 1'b1);
		add_byte(8'hF8, 1'b1);

		// wide char and nul ending a string after a drain, then a one-byte string
		drain_next = 1'b1;
		add_char('h4E2D, 3, 3, 1'b0);
		add_byte(8'h41, 1'b0);
		add_byte(8'h00, 1'b1);
		add_byte(8'h41, 1'b1);

		build_random_text();

		// worst case per item: two results each behind a long stall, plus a gap
		cycle_limit = text_q.size() * 64 + 10000;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (text_q.size() != 0 || in_valid || glyph_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (12) @(posedge clk);
		if (errors == 0 && glyph_q.size() == 0) begin
			$display("tb_utf8_decode_display_width: PASS");
		end else begin
			$display("tb_utf8_decode_display_width: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
